FILE: design/stbs_pkg.sv
// Package for the sorted-table binary search block: word types, codes,
// sequencer states and default sizes. No dependencies.

package stbs_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int COUNT_W         = 11;
	localparam int INDEX_W         = 10;
	localparam int FIELD_W         = 32;

	typedef enum logic {
		KIND_WRITE  = 1'b0,
		KIND_SEARCH = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                     kind;
		logic [INDEX_W-1:0]        entry_index;
		logic signed [FIELD_W-1:0] entry_value;
		logic signed [FIELD_W-1:0] search_key;
	} req_word_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] position;
	} rsp_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_DONE
	} engine_state_t;

endpackage

FILE: design/stbs_engine.sv
// Search engine: table memory (one write port, one registered read port)
// and the probe sequencer. Depends on stbs_pkg.

module stbs_engine #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
	parameter int VALUE_WIDTH = stbs_pkg::VALUE_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	input  stbs_pkg::req_word_t              cmd,
	input  logic [stbs_pkg::COUNT_W-1:0]     count,
	output logic                             idle,
	output logic                             res_valid,
	output stbs_pkg::rsp_word_t              res,
	input  logic                             res_take
);
	import stbs_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
	localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int IW = (AW + 1 > INDEX_W) ? AW + 1 : INDEX_W;

	logic [VALUE_WIDTH-1:0]        store_q [TABLE_DEPTH];
	logic signed [VALUE_WIDTH-1:0] rdata_q;
	logic [AW-1:0]                 raddr;

	logic                          we;
	logic [AW-1:0]                 waddr;
	logic signed [VALUE_WIDTH-1:0] wdata;

	engine_state_t                 state_q, state_d;
	logic [CW-1:0]                 lo1_q, lo1_d;    // lower bound plus one
	logic [CW-1:0]                 hi_q, hi_d;
	logic [AW-1:0]                 mid_q, mid_d;
	logic signed [VALUE_WIDTH-1:0] key_q, key_d;
	logic                          found_q, found_d;

	logic                          start;
	logic [EW-1:0]                 cnt_ext;
	logic [CW-1:0]                 n;
	logic [AW-1:0]                 mid0;
	logic                          hit, below;
	logic [CW-1:0]                 mid_c, mid_p1;
	logic [CW:0]                   sum_up, sum_dn;
	logic [AW-1:0]                 mid_up, mid_dn;

	assign idle  = (state_q == ST_IDLE);
	assign start = cmd_valid && idle && (cmd.kind == KIND_SEARCH);

	// writes outside the table are dropped
	assign we    = cmd_valid && idle && (cmd.kind == KIND_WRITE)
	               && (IW'(cmd.entry_index) < IW'(TABLE_DEPTH));
	assign waddr = AW'(cmd.entry_index);
	assign wdata = VALUE_WIDTH'($signed(cmd.entry_value[SW-1:0]));

	// count saturates at the table depth
	assign cnt_ext = EW'(count);
	assign n       = (cnt_ext > EW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cnt_ext);
	assign mid0    = AW'((n - CW'(1)) >> 1);

	assign hit    = (rdata_q == key_q);
	assign below  = (rdata_q < key_q);
	assign mid_c  = CW'(mid_q);
	assign mid_p1 = mid_c + CW'(1);
	// next midpoints for both outcomes, ready before the compare settles
	assign sum_up = (CW+1)'(mid_q) + (CW+1)'(hi_q);
	assign sum_dn = (CW+1)'(lo1_q) + (CW+1)'(mid_q) - (CW+1)'(1);
	assign mid_up = AW'(sum_up >> 1);
	assign mid_dn = AW'(sum_dn >> 1);

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		rdata_q <= store_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		lo1_q   <= lo1_d;
		hi_q    <= hi_d;
		mid_q   <= mid_d;
		key_q   <= key_d;
		found_q <= found_d;
	end

	always_comb begin
		state_d = state_q;
		lo1_d   = lo1_q;
		hi_d    = hi_q;
		mid_d   = mid_q;
		key_d   = key_q;
		found_d = found_q;
		raddr   = mid_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					key_d = VALUE_WIDTH'($signed(cmd.search_key[SW-1:0]));
					if (n == '0) begin
						found_d = 1'b0;
						state_d = ST_DONE;
					end else begin
						lo1_d   = '0;
						hi_d    = n;
						mid_d   = mid0;
						raddr   = mid0;
						state_d = ST_PROBE;
					end
				end
			end
			ST_PROBE: begin
				if (hit) begin
					found_d = 1'b1;
					state_d = ST_DONE;
				end else if (below) begin
					lo1_d = mid_p1;
					if (mid_p1 < hi_q) begin
						mid_d = mid_up;
						raddr = mid_up;
					end else begin
						found_d = 1'b0;
						state_d = ST_DONE;
					end
				end else begin
					hi_d = mid_c;
					if (lo1_q < mid_c) begin
						mid_d = mid_dn;
						raddr = mid_dn;
					end else begin
						found_d = 1'b0;
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res_valid    = (state_q == ST_DONE);
	assign res.found    = found_q;
	assign res.position = found_q ? INDEX_W'(mid_q) : '0;

endmodule

FILE: design/sorted_table_binary_search_top.sv
// Top level of the sorted-table binary search block: count register,
// request/response channels and output register. Depends on stbs_pkg, stbs_engine.
//
// req (req_valid/req_stall/req_word): KIND_WRITE stores entry_value at
//   entry_index (dropped past the table end), no response; KIND_SEARCH looks
//   for search_key among the first entries_in_use entries, one rsp word.
// rsp (rsp_valid/rsp_stall/rsp_word): found and position (0 if not found);
//   the first probe whose entry equals the key wins.
// cfg (cfg_valid/cfg_ready/cfg_data): entries_in_use, always ready; write it
//   only with no search in flight. Values above the depth act as the depth.
// Timing: a search makes P probes, at most ceil(log2(count + 1)), eleven
//   for 1024 entries: one probe per cycle through the memory's single
//   registered read port. The engine's result passes through the output
//   register before it shows as the rsp word. req_stall is high while a
//   search is in flight; the output register lets a new item in while a
//   response waits. With rsp_stall held, a second result parks in the engine
//   and further requests stall.
// Reset: arst_n clears the count and the response path; the table is not
//   cleared, so read only entries already written.

module sorted_table_binary_search_top #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
	parameter int VALUE_WIDTH = stbs_pkg::VALUE_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  stbs_pkg::req_word_t          req_word,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output stbs_pkg::rsp_word_t          rsp_word,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [stbs_pkg::COUNT_W-1:0] cfg_data
);
	import stbs_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic               eng_idle;
	logic               res_valid;
	rsp_word_t          res;
	logic               res_take;
	logic               rsp_valid_q;
	rsp_word_t          rsp_word_q;

	// count register; writes must land only while idle: the user keeps to this, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// engine takes a word only when idle
	assign req_stall = !eng_idle;

	stbs_engine #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(req_valid),
		.cmd      (req_word),
		.count    (count_q),
		.idle     (eng_idle),
		.res_valid(res_valid),
		.res      (res),
		.res_take (res_take)
	);

	// output register: load when empty or being drained
	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_word_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

endmodule

FILE: bench/stbs_search_checker.sv
// Checker for the sorted-table binary search block: keeps its own copy of the
// table and the count, predicts each search answer and compares. Depends on stbs_pkg.
`timescale 1ns / 1ps

module stbs_search_checker #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic                         req_stall,
	input  stbs_pkg::req_word_t          req_word,
	input  logic                         rsp_valid,
	input  logic                         rsp_stall,
	input  stbs_pkg::rsp_word_t          rsp_word,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [stbs_pkg::COUNT_W-1:0] cfg_data,
	output int                           fail_count,
	output int                           pending
);
	import stbs_pkg::*;

	logic signed [FIELD_W-1:0] entry_copy [TABLE_DEPTH];
	logic [COUNT_W-1:0]        span;
	rsp_word_t                 answers_due [$];
	int                        fails;

	// open-bound search over the first span entries, first matching probe wins
	function automatic rsp_word_t search_copy(input logic signed [FIELD_W-1:0] key);
		rsp_word_t                 r;
		int                        lo;
		int                        hi;
		int                        mid;
		bit                        hit;
		logic signed [FIELD_W-1:0] v;
		r = '0;
		hit = 1'b0;
		lo = -1;
		hi = (span > TABLE_DEPTH) ? TABLE_DEPTH : int'(span);
		while (!hit && (lo < hi - 1)) begin
			mid = (lo + hi) / 2;
			v = entry_copy[mid];
			if (v == key) begin
				hit = 1'b1;
				r.found = 1'b1;
				r.position = INDEX_W'(mid);
			end else if (v < key) begin
				lo = mid;
			end else begin
				hi = mid;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;
		if (!arst_n) begin
			span = '0;
			answers_due.delete();
			fails = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				span = cfg_data;
			if (rsp_valid && !rsp_stall) begin
				if (answers_due.size() == 0) begin
					$display("%0t unexpected word: expected none, actual found=%0d position=%0d",
						$time, rsp_word.found, rsp_word.position);
					fails++;
				end else begin
					want = answers_due.pop_front();
					if (rsp_word.found !== want.found) begin
						$display("%0t found mismatch: expected %0d, actual %0d",
							$time, want.found, rsp_word.found);
						fails++;
					end
					if (rsp_word.position !== want.position) begin
						$display("%0t position mismatch: expected %0d, actual %0d",
							$time, want.position, rsp_word.position);
						fails++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				if (req_word.kind == KIND_WRITE)
					entry_copy[req_word.entry_index] = req_word.entry_value;
				else
					answers_due.push_back(search_copy(req_word.search_key));
			end
			pending <= answers_due.size();
			fail_count <= fails;
		end
	end

endmodule

FILE: bench/sorted_table_binary_search_top_test.sv
// Testbench top for the sorted-table binary search block: drives request,
// response and count channels and gives the verdict. Depends on stbs_pkg,
// stbs_search_checker and the block itself.
`timescale 1ns / 1ps

module sorted_table_binary_search_top_test;
	import stbs_pkg::*;

	localparam int DEPTH          = TABLE_DEPTH_DEF;
	localparam int GAP_MAX        = 6;
	localparam int SETTLE         = 20;    // covers a write in flight plus the output stage
	localparam int SQUEEZE_CYCLES = 300;   // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moved on any channel
	localparam int RANDOM_ITEMS   = 720;

	localparam logic signed [FIELD_W-1:0] VAL_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
	localparam logic signed [FIELD_W-1:0] VAL_MAX = ~VAL_MIN;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	req_word_t          req_word = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	rsp_word_t          rsp_word;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [COUNT_W-1:0] cfg_data = '0;

	int fail_count;
	int pending;

	bit calm = 1'b0;        // both sides run without idling while set
	int squeeze_req = 0;    // bumped by the stimulus to ask for a long hold-off
	int idle_cycles = 0;
	int sent = 0;
	int live = 0;           // entries covered by the current count

	// stimulus-side copy of table values, used only to choose keys from table values
	logic signed [FIELD_W-1:0] shadow [DEPTH];

	// entries on the two outer probe paths of a full-depth search
	int spine_idx [$];

	sorted_table_binary_search_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_word (req_word),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_word (rsp_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	stbs_search_checker #(.TABLE_DEPTH(DEPTH)) watch (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: any word moving on any channel restarts the count.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Response side. Per word it draws a random stall, at most GAP_MAX, then takes
	// the word. A pending squeeze request turns the stall into a long hold-off,
	// so the output register and the engine both fill and req_stall rises.
	// rsp_stall gets at most one assignment per time step: it is only raised
	// when the stall is non-zero, and lowered after the stall has run out.
	initial begin : rsp_side
		int hold;
		int squeeze_seen;
		squeeze_seen = 0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (squeeze_req != squeeze_seen) begin
				squeeze_seen = squeeze_req;
				hold = SQUEEZE_CYCLES;
			end else if (calm) begin
				hold = 0;
			end else begin
				hold = $urandom_range(0, GAP_MAX);
			end
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
		end
	end

	// Offer one request word after a random gap and hold it until taken.
	// Valid stays high across a zero gap, so it is never lowered and raised
	// in the same step.
	task automatic send_word(input req_word_t w);
		int gap;
		gap = calm ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_word <= w;
		do @(posedge clk); while (req_stall);
		sent++;
	endtask

	// Unused fields carry random bits so every input bit toggles.
	task automatic write_entry(input int idx, input logic signed [FIELD_W-1:0] val);
		req_word_t w;
		w.kind = KIND_WRITE;
		w.entry_index = INDEX_W'(idx);
		w.entry_value = val;
		w.search_key = $urandom;
		send_word(w);
		shadow[idx] = val;
	endtask

	task automatic probe(input logic signed [FIELD_W-1:0] key);
		req_word_t w;
		w.kind = KIND_SEARCH;
		w.entry_index = INDEX_W'($urandom);
		w.entry_value = $urandom;
		w.search_key = key;
		send_word(w);
	endtask

	// Stop offering, wait for every answer, then let a trailing write settle.
	// The first edge lets the checker's pending count catch up with the last
	// accepted word.
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Count register is written only with the block idle.
	task automatic set_count(input int n);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= COUNT_W'(n);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		live = (n > DEPTH) ? DEPTH : n;
	endtask

	// Ascending values from a random start; a small step gives duplicate runs,
	// and values pile up at the top when they reach the maximum.
	task automatic load_sorted(input int n, input int step_max);
		longint v;
		int     pick;
		pick = $urandom_range(0, 3);
		if (pick == 0)
			v = longint'(VAL_MIN);
		else if (pick == 1)
			v = longint'(VAL_MAX) - (longint'(n) * step_max) / 2;
		else
			v = longint'($signed($urandom));
		for (int i = 0; i < n; i++) begin
			write_entry(i, FIELD_W'(v));
			v += $urandom_range(0, step_max);
			if (v > longint'(VAL_MAX))
				v = longint'(VAL_MAX);
		end
	endtask

	// Broken table: answers just follow the probe order.
	task automatic load_scrambled(input int n);
		for (int i = 0; i < n; i++)
			write_entry(i, $urandom);
	endtask

	// Ascending values only on the leftmost and rightmost probe paths of a
	// full-depth search; keys from these entries or at the extremes never
	// leave those paths.
	task automatic load_spines();
		bit     on_path [DEPTH];
		int     lo;
		int     hi;
		int     mid;
		longint v;
		on_path = '{default: 1'b0};
		lo = -1;
		hi = DEPTH;
		while (lo < hi - 1) begin
			mid = (lo + hi) / 2;
			on_path[mid] = 1'b1;
			hi = mid;
		end
		lo = -1;
		hi = DEPTH;
		while (lo < hi - 1) begin
			mid = (lo + hi) / 2;
			on_path[mid] = 1'b1;
			lo = mid;
		end
		spine_idx.delete();
		v = longint'(VAL_MIN) + $urandom_range(0, 3);
		for (int i = 0; i < DEPTH; i++) begin
			if (on_path[i]) begin
				spine_idx.push_back(i);
				write_entry(i, FIELD_W'(v));
				v += $urandom_range(0, 1 << 26);
			end
		end
	endtask

	// Full-depth searches that stay on the loaded paths.
	task automatic spine_run(input int count);
		int c;
		for (int i = 0; i < count; i++) begin
			c = $urandom_range(0, 9);
			if (c == 0)
				probe(VAL_MIN);
			else if (c == 1)
				probe(VAL_MAX);
			else
				probe(shadow[spine_idx[$urandom_range(0, spine_idx.size() - 1)]]);
		end
	endtask

	// Mostly keys present in the table, some neighbors, extremes and noise.
	function automatic logic signed [FIELD_W-1:0] pick_key();
		int c;
		c = $urandom_range(0, 19);
		if (live > 0 && c < 12)
			return shadow[$urandom_range(0, live - 1)];
		if (live > 0 && c < 15)
			return shadow[$urandom_range(0, live - 1)] + ($urandom_range(0, 1) ? 1 : -1);
		if (c < 16)
			return VAL_MIN;
		if (c < 17)
			return VAL_MAX;
		return $urandom;
	endfunction

	// Searches with an occasional stray write mixed in; a stray write inside
	// the covered range may break the ordering, which is allowed.
	task automatic search_run(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				write_entry($urandom_range(0, DEPTH - 1), $urandom);
			else
				probe(pick_key());
		end
	endtask

	initial begin : stimulus
		int n;
		int step;
		int k;
		int phase;
		phase = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Count still at its reset value: empty table, nothing is probed.
		probe(0);
		probe(VAL_MIN);
		probe(VAL_MAX);

		// Small table with both extremes and a run of duplicates.
		write_entry(0, VAL_MIN);
		write_entry(1, -5);
		write_entry(2, 7);
		write_entry(3, 7);
		write_entry(4, 7);
		write_entry(DEPTH - 1, VAL_MAX);
		set_count(5);
		probe(VAL_MIN);
		probe(7);
		probe(-5);
		probe(0);
		probe(VAL_MAX);
		probe(8);

		// Single entry, then back to empty with the register written.
		set_count(1);
		probe(VAL_MIN);
		probe(3);
		set_count(0);
		probe(7);

		// Full count, then a count past the depth that the block saturates,
		// with only the outer probe paths loaded.
		load_spines();
		set_count(DEPTH);
		spine_run(30);
		set_count({COUNT_W{1'b1}});
		spine_run(20);

		// Random phases: reload a prefix, set the count, search.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			phase++;
			calm = ($urandom_range(0, 4) == 0);
			k = $urandom_range(0, 19);
			if (k == 0)
				n = 0;
			else if (k < 3)
				n = $urandom_range(41, 200);
			else
				n = $urandom_range(1, 40);
			case ($urandom_range(0, 3))
				0: step = 1;
				1: step = 100;
				2: step = 1 << 20;
				default: step = 1 << 26;
			endcase
			if ($urandom_range(0, 4) == 0)
				load_scrambled(n);
			else
				load_sorted(n, step);
			set_count(n);
			// one phase runs against a receiver that holds off for a long time
			if (phase == 3) begin
				squeeze_req++;
				search_run(40);
			end else begin
				search_run($urandom_range(8, 30));
			end
		end

		calm = 1'b0;
		drain();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
design/stbs_pkg.sv
design/stbs_engine.sv
design/sorted_table_binary_search_top.sv
bench/stbs_search_checker.sv
bench/sorted_table_binary_search_top_test.sv
